FILE: hw/rtl/keyed_sexpr_scanner_macros.svh
// ----------------------------------------------------------------------------
// keyed sexpr scanner assertion macros
// shared property forms used by the scanner rtl
// ----------------------------------------------------------------------------
`ifndef KEYED_SEXPR_SCANNER_MACROS_SVH
`define KEYED_SEXPR_SCANNER_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define KSS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define KSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/kss_pkg.sv
// ----------------------------------------------------------------------------
// kss_pkg
// types, codes and constants shared by the keyed sexpr scanner modules
// ----------------------------------------------------------------------------
package kss_pkg;

  localparam int MAX_KEY_LEN_DEF = 16;
  localparam int OFFSET_BITS_DEF = 32;
  localparam int DEPTH_BITS_DEF  = 16;

  localparam int OFS_OUT_W = 32;
  localparam int KEY_LEN_W = 5;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RST = 5'd6;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NEL    = 8'h85;
  localparam logic [7:0] CH_NBSP   = 8'hA0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LEN  = 2'd0,
    CFG_KEY_LOW  = 2'd1,
    CFG_KEY_HIGH = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_DONE  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_OPEN  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    MODE_SEARCH = 2'd0,
    MODE_KEY    = 2'd1,
    MODE_EXPR   = 2'd2
  } mode_e;

  typedef struct packed {
    kind_e                kind;
    logic [OFS_OUT_W-1:0] start_offset;
    logic [OFS_OUT_W-1:0] end_offset;
    logic                 stream_end;
  } result_t;

endpackage

FILE: hw/rtl/keyed_sexpr_scanner.sv
// ----------------------------------------------------------------------------
// keyed_sexpr_scanner
// finds keyed s-expressions in a byte stream and reports their byte offsets
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle, back to back, as long as the result side
// keeps up. A byte lands in the input register, is scanned by the core against
// the string, comment, key and depth state, and any result it causes is
// registered in the output register. The output register lets a new byte enter
// while a finished result still waits to be taken. The user must write the key
// registers only while no byte is in flight; the block itself does not enforce
// this.
module keyed_sexpr_scanner #(
  parameter int MAX_KEY_LEN = kss_pkg::MAX_KEY_LEN_DEF,
  parameter int OFFSET_BITS = kss_pkg::OFFSET_BITS_DEF,
  parameter int DEPTH_BITS  = kss_pkg::DEPTH_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kss_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [kss_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    char_code_i,
  input  logic                          stream_last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    kind_o,
  output logic [kss_pkg::OFS_OUT_W-1:0] start_offset_o,
  output logic [kss_pkg::OFS_OUT_W-1:0] end_offset_o,
  output logic                          stream_end_o
);

  localparam int KIDX_W = $clog2(MAX_KEY_LEN + 1);

  logic                        in_vld_q;
  logic [7:0]                  in_char_q;
  logic                        in_last_q;
  logic                        adv;
  logic [KIDX_W-1:0]           klen;
  logic [MAX_KEY_LEN-1:0][7:0] key;
  logic                        core_vld;
  kss_pkg::result_t            core_res;
  logic                        res_vld_q;
  kss_pkg::result_t            res_q;

  assign adv        = in_vld_q && (!res_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_char_q <= char_code_i;
      in_last_q <= stream_last_i;
    end
  end

  kss_cfg #(
    .MAX_KEY_LEN (MAX_KEY_LEN)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .klen_o      (klen),
    .key_o       (key)
  );

  kss_core #(
    .MAX_KEY_LEN (MAX_KEY_LEN),
    .OFFSET_BITS (OFFSET_BITS),
    .DEPTH_BITS  (DEPTH_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .char_i    (in_char_q),
    .last_i    (in_last_q),
    .klen_i    (klen),
    .key_i     (key),
    .res_vld_o (core_vld),
    .res_o     (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (adv) begin
      res_vld_q <= core_vld;
    end else if (!out_stall_i) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && core_vld) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o    = res_vld_q;
  assign kind_o         = res_q.kind;
  assign start_offset_o = res_q.start_offset;
  assign end_offset_o   = res_q.end_offset;
  assign stream_end_o   = res_q.stream_end;

endmodule

FILE: hw/rtl/kss_cfg.sv
// ----------------------------------------------------------------------------
// kss_cfg
// key length and key character registers, with length clamp and byte split
// ----------------------------------------------------------------------------
module kss_cfg #(
  parameter int MAX_KEY_LEN = kss_pkg::MAX_KEY_LEN_DEF,
  localparam int KIDX_W     = $clog2(MAX_KEY_LEN + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kss_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [kss_pkg::CFG_W-1:0]     cfg_wdata_i,
  output logic [KIDX_W-1:0]             klen_o,
  output logic [MAX_KEY_LEN-1:0][7:0]   key_o
);

  logic [kss_pkg::KEY_LEN_W-1:0] key_len_q;
  logic [kss_pkg::CFG_W-1:0]     key_lo_q;
  logic [kss_pkg::CFG_W-1:0]     key_hi_q;
  logic [2*kss_pkg::CFG_W-1:0]   key_all;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q <= kss_pkg::KEY_LEN_RST;
      key_lo_q  <= '0;
      key_hi_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (kss_pkg::cfg_idx_e'(cfg_idx_i))
        kss_pkg::CFG_KEY_LEN:  key_len_q <= cfg_wdata_i[kss_pkg::KEY_LEN_W-1:0];
        kss_pkg::CFG_KEY_LOW:  key_lo_q  <= cfg_wdata_i;
        kss_pkg::CFG_KEY_HIGH: key_hi_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign key_all = {key_hi_q, key_lo_q};

  // lengths above the supported maximum act as the maximum
  assign klen_o = (key_len_q > kss_pkg::KEY_LEN_W'(MAX_KEY_LEN))
                ? KIDX_W'(MAX_KEY_LEN) : key_len_q[KIDX_W-1:0];

  for (genvar i = 0; i < MAX_KEY_LEN; i++) begin : g_key
    assign key_o[i] = key_all[8*i +: 8];
  end

endmodule

FILE: hw/rtl/kss_core.sv
// ----------------------------------------------------------------------------
// kss_core
// per-byte scan state: string and comment tracking, key match, depth count
// ----------------------------------------------------------------------------
module kss_core #(
  parameter int MAX_KEY_LEN = kss_pkg::MAX_KEY_LEN_DEF,
  parameter int OFFSET_BITS = kss_pkg::OFFSET_BITS_DEF,
  parameter int DEPTH_BITS  = kss_pkg::DEPTH_BITS_DEF,
  localparam int KIDX_W     = $clog2(MAX_KEY_LEN + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic [7:0]                  char_i,
  input  logic                        last_i,
  input  logic [KIDX_W-1:0]           klen_i,
  input  logic [MAX_KEY_LEN-1:0][7:0] key_i,
  output logic                        res_vld_o,
  output kss_pkg::result_t            res_o
);

`include "keyed_sexpr_scanner_macros.svh"

  localparam int KSEL_W = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam int OUT_W  = kss_pkg::OFS_OUT_W;
  localparam logic [DEPTH_BITS-1:0]  DEPTH_MAX = {DEPTH_BITS{1'b1}};
  localparam logic [OFFSET_BITS-1:0] POS_MAX   = {OFFSET_BITS{1'b1}};

  kss_pkg::mode_e          mode_q, mode_d;
  logic                    quote_q, quote_d;
  logic                    esc_q, esc_d;
  logic                    cmt_q, cmt_d;
  logic [KIDX_W-1:0]       kidx_q, kidx_d;
  logic [DEPTH_BITS-1:0]   depth_q, depth_d;
  logic [OFFSET_BITS-1:0]  pos_q, pos_d;
  logic [OFFSET_BITS-1:0]  open_q, open_d;

  logic                    code;
  logic                    is_bnd;
  logic [DEPTH_BITS-1:0]   depth_app;
  logic                    retry;
  logic                    done;
  logic                    open_flag;

  // string and comment tracker
  always_comb begin
    code    = 1'b0;
    quote_d = quote_q;
    esc_d   = esc_q;
    cmt_d   = cmt_q;
    priority if (cmt_q) begin
      if (char_i == kss_pkg::CH_LF || char_i == kss_pkg::CH_CR) cmt_d = 1'b0;
    end else if (quote_q) begin
      priority if (esc_q) esc_d = 1'b0;
      else if (char_i == kss_pkg::CH_BSLASH) esc_d = 1'b1;
      else if (char_i == kss_pkg::CH_QUOTE) quote_d = 1'b0;
      else ;
    end else if (char_i == kss_pkg::CH_SEMI) begin
      cmt_d = 1'b1;
    end else if (char_i == kss_pkg::CH_QUOTE) begin
      quote_d = 1'b1;
    end else begin
      code = 1'b1;
    end
  end

  assign is_bnd = (char_i >= kss_pkg::CH_TAB && char_i <= kss_pkg::CH_CR)
               || char_i == kss_pkg::CH_SPACE  || char_i == kss_pkg::CH_NEL
               || char_i == kss_pkg::CH_NBSP   || char_i == kss_pkg::CH_LPAREN
               || char_i == kss_pkg::CH_RPAREN || char_i == kss_pkg::CH_QUOTE
               || char_i == kss_pkg::CH_SEMI;

  // saturating depth update for code bytes
  always_comb begin
    depth_app = depth_q;
    if (code && char_i == kss_pkg::CH_LPAREN && depth_q != DEPTH_MAX) begin
      depth_app = depth_q + 1'b1;
    end else if (code && char_i == kss_pkg::CH_RPAREN && depth_q != '0) begin
      depth_app = depth_q - 1'b1;
    end
  end

  // next state
  always_comb begin
    mode_d = mode_q;
    kidx_d = kidx_q;
    depth_d = depth_q;
    open_d = open_q;
    retry  = 1'b0;
    done   = 1'b0;
    unique case (mode_q)
      kss_pkg::MODE_KEY: begin
        if (kidx_q < klen_i) begin
          if (char_i == key_i[kidx_q[KSEL_W-1:0]]) begin
            kidx_d  = kidx_q + 1'b1;
            depth_d = depth_app;
            if (depth_app == '0) mode_d = kss_pkg::MODE_SEARCH;
          end else begin
            mode_d = kss_pkg::MODE_SEARCH;
            retry  = 1'b1;
          end
        end else if (is_bnd) begin
          depth_d = depth_app;
          if (depth_app == '0) begin
            done   = 1'b1;
            mode_d = kss_pkg::MODE_SEARCH;
          end else begin
            mode_d = kss_pkg::MODE_EXPR;
          end
        end else begin
          mode_d = kss_pkg::MODE_SEARCH;
          retry  = 1'b1;
        end
      end
      kss_pkg::MODE_EXPR: begin
        depth_d = depth_app;
        if (depth_app == '0) begin
          done   = 1'b1;
          mode_d = kss_pkg::MODE_SEARCH;
        end
      end
      default: begin
        mode_d = kss_pkg::MODE_SEARCH;
        retry  = 1'b1;
      end
    endcase
    // failing byte may open a new candidate
    if (retry && code && char_i == kss_pkg::CH_LPAREN) begin
      mode_d  = kss_pkg::MODE_KEY;
      kidx_d  = '0;
      depth_d = DEPTH_BITS'(1);
      open_d  = pos_q;
    end
  end

  assign pos_d = (pos_q != POS_MAX) ? pos_q + 1'b1 : pos_q;

  // result
  always_comb begin
    open_flag = (mode_d == kss_pkg::MODE_EXPR)
             || (mode_d == kss_pkg::MODE_KEY && kidx_d >= klen_i);
    res_vld_o = done || last_i;
    res_o.stream_end = last_i;
    res_o.end_offset = OUT_W'(pos_q);
    if (done) begin
      res_o.kind         = kss_pkg::KIND_DONE;
      res_o.start_offset = OUT_W'(open_d);
    end else if (open_flag) begin
      res_o.kind         = kss_pkg::KIND_OPEN;
      res_o.start_offset = OUT_W'(open_d);
    end else begin
      res_o.kind         = kss_pkg::KIND_EMPTY;
      res_o.start_offset = '0;
    end
  end

  // last byte of a stream clears everything for the next one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= kss_pkg::MODE_SEARCH;
      quote_q <= 1'b0;
      esc_q   <= 1'b0;
      cmt_q   <= 1'b0;
      kidx_q  <= '0;
      depth_q <= '0;
      pos_q   <= '0;
      open_q  <= '0;
    end else if (adv_i) begin
      if (last_i) begin
        mode_q  <= kss_pkg::MODE_SEARCH;
        quote_q <= 1'b0;
        esc_q   <= 1'b0;
        cmt_q   <= 1'b0;
        kidx_q  <= '0;
        depth_q <= '0;
        pos_q   <= '0;
        open_q  <= '0;
      end else begin
        mode_q  <= mode_d;
        quote_q <= quote_d;
        esc_q   <= esc_d;
        cmt_q   <= cmt_d;
        kidx_q  <= kidx_d;
        depth_q <= depth_d;
        pos_q   <= pos_d;
        open_q  <= open_d;
      end
    end
  end

  `KSS_ASSERT_IMPL(a_open_has_depth,
    mode_q == kss_pkg::MODE_KEY || mode_q == kss_pkg::MODE_EXPR, depth_q != '0,
    "open candidate with zero depth")
  `KSS_ASSERT_NEXT(a_last_clears, adv_i && last_i,
    mode_q == kss_pkg::MODE_SEARCH && pos_q == '0 && depth_q == '0,
    "stream state not cleared after last byte")
  `KSS_ASSERT_NEXT(a_pos_step, adv_i && !last_i,
    pos_q == $past(pos_q) + 1'b1 || $past(pos_q) == POS_MAX,
    "position did not advance by one")
  `KSS_ASSERT_IMPL(a_end_kind_on_last, res_vld_o && res_o.kind != kss_pkg::KIND_DONE,
    last_i, "end-of-stream result on a byte that is not last")

endmodule
